// ----- src/iwmt_pkg.sv -----
// shared types and constants for the io window map table
`timescale 1ns / 1ps
`default_nettype none

package iwmt_pkg;

    localparam int MAX_WIN_DEF = 16;

    localparam logic [1:0] OP_MAP     = 2'd0;
    localparam logic [1:0] OP_UNMAP   = 2'd1;
    localparam logic [1:0] OP_RESOLVE = 2'd2;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_REMAP,
        ACT_FRESH,
        ACT_UNMAP,
        ACT_HIT
    } t_act;

    typedef struct packed {
        logic load;
        logic scan;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_end;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- src/iwmt_ctrl.sv -----
// controller for the window table: accept, slot scan, table update, result hold
`timescale 1ns / 1ps
`default_nettype none

module iwmt_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output iwmt_pkg::t_dp_cmd       o_cmd,
    input  wire iwmt_pkg::t_dp_stat i_stat
);
    import iwmt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   accept;
    logic   upd_go;

    assign accept  = (r_state == S_IDLE) && i_valid;
    // the update waits until the result word ahead of it has left
    assign upd_go  = (r_state == S_UPD) && (!r_out_vld || !i_stall);
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_vld;

    assign o_cmd.load   = accept;
    assign o_cmd.scan   = (r_state == S_SCAN);
    assign o_cmd.update = upd_go;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.scan_end) n_state = S_UPD;
            end
            S_UPD: begin
                if (upd_go) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (upd_go) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

`default_nettype wire

// ----- src/iwmt_dp.sv -----
// datapath for the window table: slot memories, slot compare, counters, result word
`timescale 1ns / 1ps
`default_nettype none

module iwmt_dp #(
    parameter int MAX_WINDOWS = iwmt_pkg::MAX_WIN_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire iwmt_pkg::t_dp_cmd i_cmd,
    output iwmt_pkg::t_dp_stat     o_stat,
    input  wire logic [1:0]        i_operation,
    input  wire logic [31:0]       i_io_address,
    input  wire logic [31:0]       i_ea_address,
    input  wire logic [31:0]       i_length,
    output logic                   o_ok,
    output logic [31:0]            o_translated_address,
    output logic [31:0]            o_window_generation,
    output logic [31:0]            o_table_epoch,
    output logic [4:0]             o_live_windows
);
    import iwmt_pkg::*;

    localparam int IW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam logic [IW-1:0] LAST = IW'(MAX_WINDOWS - 1);

    // request word
    logic [1:0]  r_op;
    logic [31:0] r_io;
    logic [31:0] r_ea;
    logic [31:0] r_len;
    logic [32:0] r_rend;

    // slot memories
    logic [31:0] m_start  [MAX_WINDOWS];
    logic [31:0] m_target [MAX_WINDOWS];
    logic [31:0] m_length [MAX_WINDOWS];
    logic [31:0] m_gen    [MAX_WINDOWS];
    logic [31:0] r_start_q;
    logic [31:0] r_tgt_q;
    logic [31:0] r_len_q;
    logic [31:0] r_gen_q;

    logic [MAX_WINDOWS-1:0] r_live;
    logic [MAX_WINDOWS-1:0] r_gen_wr;

    // scan pointers
    logic [IW-1:0] r_rd_idx;
    logic [IW-1:0] r_cmp_idx;
    logic          r_cmp_vld;

    logic          r_free_found;
    logic [IW-1:0] r_free_idx;
    logic [31:0]   r_free_gen;

    // outcome of the scan
    t_act          r_act;
    logic [IW-1:0] r_act_idx;
    logic [31:0]   r_act_gen;
    logic [31:0]   r_hit_off;
    logic [31:0]   r_hit_tgt;
    logic          r_changed;

    logic [31:0] r_epoch;
    logic [4:0]  r_live_cnt;
    logic        r_ok;
    logic [31:0] r_xa;
    logic [31:0] r_gen_out;

    logic        slot_live;
    logic [31:0] slot_gen;
    logic [32:0] slot_end;
    logic        eq_start;
    logic        meet;
    logic        fit;
    logic [31:0] off;
    logic        skip;
    logic        hit_now;
    t_act        hit_act;
    logic        take_free;
    logic        scan_end;
    t_act        end_act;
    logic        we_data;
    logic        we_gen;
    logic [31:0] gen_next;

    assign slot_live = r_live[r_cmp_idx];
    assign slot_gen  = r_gen_wr[r_cmp_idx] ? r_gen_q : 32'd0;
    assign slot_end  = {1'b0, r_start_q} + {1'b0, r_len_q};
    assign eq_start  = (r_start_q == r_io);
    // overlap with sums taken modulo 2^32
    assign meet      = (r_io < slot_end[31:0]) && (r_start_q < r_rend[31:0]);
    // access range lies wholly inside the window
    assign fit       = (r_io >= r_start_q) && (r_rend <= slot_end);
    assign off       = r_io - r_start_q;
    assign skip      = ((r_op == OP_MAP) && (r_len == 32'd0))
                    || ((r_op != OP_MAP) && (r_op != OP_UNMAP) && (r_op != OP_RESOLVE));
    assign take_free = r_cmp_vld && !slot_live && !r_free_found && (r_op == OP_MAP);

    always_comb begin
        hit_now = 1'b0;
        hit_act = ACT_NONE;
        if (r_cmp_vld && slot_live) begin
            unique case (r_op)
                OP_MAP: begin
                    if (eq_start) begin
                        hit_now = 1'b1;
                        hit_act = ACT_REMAP;
                    end else if (meet) begin
                        hit_now = 1'b1;
                        hit_act = ACT_NONE;
                    end
                end
                OP_UNMAP: begin
                    if (eq_start) begin
                        hit_now = 1'b1;
                        hit_act = ACT_UNMAP;
                    end
                end
                OP_RESOLVE: begin
                    if (fit) begin
                        hit_now = 1'b1;
                        hit_act = ACT_HIT;
                    end
                end
                default: begin
                    hit_now = 1'b0;
                    hit_act = ACT_NONE;
                end
            endcase
        end
    end

    assign scan_end = i_cmd.scan && (skip || (r_cmp_vld && (hit_now || (r_cmp_idx == LAST))));
    assign o_stat.scan_end = scan_end;

    always_comb begin
        priority if (skip) begin
            end_act = ACT_NONE;
        end else if (hit_now) begin
            end_act = hit_act;
        end else if ((r_op == OP_MAP) && (r_free_found || take_free)) begin
            end_act = ACT_FRESH;
        end else begin
            end_act = ACT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_io   <= i_io_address;
            r_ea   <= i_ea_address;
            r_len  <= i_length;
            r_rend <= {1'b0, i_io_address} + {1'b0, i_length};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx     <= '0;
            r_cmp_idx    <= '0;
            r_cmp_vld    <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_rd_idx     <= '0;
            r_cmp_vld    <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.scan) begin
            r_cmp_vld <= 1'b1;
            r_cmp_idx <= r_rd_idx;
            if (r_rd_idx != LAST) r_rd_idx <= r_rd_idx + IW'(1);
            if (take_free) r_free_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && take_free) begin
            r_free_idx <= r_cmp_idx;
            r_free_gen <= slot_gen;
        end
        if (scan_end) begin
            r_act_idx <= (hit_now || take_free) ? r_cmp_idx : r_free_idx;
            r_act_gen <= (hit_now || take_free) ? slot_gen : r_free_gen;
            r_hit_off <= off;
            r_hit_tgt <= r_tgt_q;
            r_changed <= (r_len_q != r_len) || (r_tgt_q != r_ea);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= ACT_NONE;
        end else if (scan_end) begin
            r_act <= end_act;
        end
    end

    // table update
    assign we_data  = i_cmd.update
                   && ((r_act == ACT_FRESH) || ((r_act == ACT_REMAP) && r_changed));
    assign we_gen   = we_data || (i_cmd.update && (r_act == ACT_UNMAP));
    assign gen_next = r_act_gen + 32'd1;

    always_ff @(posedge i_clk) begin
        r_start_q <= m_start[r_rd_idx];
        r_tgt_q   <= m_target[r_rd_idx];
        r_len_q   <= m_length[r_rd_idx];
        r_gen_q   <= m_gen[r_rd_idx];
        if (we_data) begin
            m_start[r_act_idx]  <= r_io;
            m_target[r_act_idx] <= r_ea;
            m_length[r_act_idx] <= r_len;
        end
        if (we_gen) begin
            m_gen[r_act_idx] <= gen_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live     <= '0;
            r_gen_wr   <= '0;
            r_epoch    <= '0;
            r_live_cnt <= '0;
        end else begin
            if (we_gen) begin
                r_gen_wr[r_act_idx] <= 1'b1;
                r_epoch             <= r_epoch + 32'd1;
            end
            if (i_cmd.update && (r_act == ACT_FRESH)) begin
                r_live[r_act_idx] <= 1'b1;
                r_live_cnt        <= r_live_cnt + 5'd1;
            end else if (i_cmd.update && (r_act == ACT_UNMAP)) begin
                r_live[r_act_idx] <= 1'b0;
                r_live_cnt        <= r_live_cnt - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_ok      <= (r_act != ACT_NONE);
            r_xa      <= (r_act == ACT_HIT) ? (r_hit_tgt + r_hit_off) : 32'd0;
            r_gen_out <= (r_act == ACT_HIT) ? r_act_gen : 32'd0;
        end
    end

    assign o_ok                 = r_ok;
    assign o_translated_address = r_xa;
    assign o_window_generation  = r_gen_out;
    assign o_table_epoch        = r_epoch;
    assign o_live_windows       = r_live_cnt;

endmodule

`default_nettype wire

// ----- src/io_window_map_table_top.sv -----
// Address window table: MAX_WINDOWS slots that map I/O address windows to effective
// addresses, with map, unmap and resolve requests and one result word per request.
// Each request walks the slots in order through a single read port of the slot
// memory, one slot compared per cycle, and stops at the first slot that decides it.
// A zero-length map or an unknown operation is decided without comparing any slot,
// and the next request is held off until the current one has updated the table. A
// new request is taken while the previous result word still waits at the output.
// All slots, the epoch and the live count are empty right after reset; no clearing
// pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module io_window_map_table_top #(
    parameter int MAX_WINDOWS = iwmt_pkg::MAX_WIN_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [31:0] i_io_address,
    input  wire logic [31:0] i_ea_address,
    input  wire logic [31:0] i_length,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_ok,
    output logic [31:0]      o_translated_address,
    output logic [31:0]      o_window_generation,
    output logic [31:0]      o_table_epoch,
    output logic [4:0]       o_live_windows
);
    import iwmt_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    iwmt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    iwmt_dp #(
        .MAX_WINDOWS (MAX_WINDOWS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .i_operation          (i_operation),
        .i_io_address         (i_io_address),
        .i_ea_address         (i_ea_address),
        .i_length             (i_length),
        .o_ok                 (o_ok),
        .o_translated_address (o_translated_address),
        .o_window_generation  (o_window_generation),
        .o_table_epoch        (o_table_epoch),
        .o_live_windows       (o_live_windows)
    );

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// self-checking testbench for the io window map table
`timescale 1ns / 1ps

module testbench;
    import iwmt_pkg::*;

    localparam int SLOTS = MAX_WIN_DEF;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    localparam int NUM_REGIONS = 24;
    localparam int RANDOM_WORDS = 550;
    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL_CYCLES = 40;
    localparam int MAX_REPORTS = 60;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] io;
        logic [31:0] ea;
        logic [31:0] len;
        bit          hold;    // hold back until every result is in
    } t_window_req;

    typedef struct {
        logic        ok;
        logic [31:0] xlat;
        logic [31:0] gen;
        logic [31:0] epoch;
        logic [4:0]  live;
    } t_window_rsp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_operation = OP_MAP;
    logic [31:0] i_io_address = '0;
    logic [31:0] i_ea_address = '0;
    logic [31:0] i_length = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_ok;
    logic [31:0] o_translated_address;
    logic [31:0] o_window_generation;
    logic [31:0] o_table_epoch;
    logic [4:0]  o_live_windows;

    io_window_map_table_top #(
        .MAX_WINDOWS(SLOTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_operation(i_operation),
        .i_io_address(i_io_address),
        .i_ea_address(i_ea_address),
        .i_length(i_length),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_ok(o_ok),
        .o_translated_address(o_translated_address),
        .o_window_generation(o_window_generation),
        .o_table_epoch(o_table_epoch),
        .o_live_windows(o_live_windows)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the window table
    logic [31:0] tbl_start[SLOTS];
    logic [31:0] tbl_target[SLOTS];
    logic [31:0] tbl_len[SLOTS];
    logic [31:0] tbl_gen[SLOTS];
    bit          tbl_live[SLOTS];
    logic [31:0] tbl_epoch = '0;
    logic [4:0]  tbl_count = '0;

    t_window_req pending_q[$];
    t_window_rsp expected_q[$];
    t_window_req cur_req;
    t_window_req next_req;

    int mismatch_count = 0;
    int gap_left = 0;
    int burst_left = 1;
    int stall_mode = 0;
    int mode_left = 0;
    int idle_cycles = 0;
    bit timed_out = 1'b0;

    // region bookkeeping for the stimulus generator
    logic [31:0] reg_start[NUM_REGIONS];
    logic [31:0] reg_ea[NUM_REGIONS];
    logic [31:0] reg_len[NUM_REGIONS];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic predict_window_op(input t_window_req r);
        t_window_rsp rsp;
        int          free_idx;
        int          i;
        bit          decided;
        logic [31:0] req_end;
        logic [31:0] win_end;
        logic [31:0] off;
        logic [31:0] room;
        free_idx = -1;
        decided = 1'b0;
        rsp.ok = 1'b0;
        rsp.xlat = '0;
        rsp.gen = '0;
        case (r.op)
            OP_MAP: begin
                req_end = r.io + r.len;
                if (r.len == '0)
                    decided = 1'b1;
                for (i = 0; i < SLOTS; i++) begin
                    if (!decided) begin
                        win_end = tbl_start[i] + tbl_len[i];
                        if (!tbl_live[i]) begin
                            if (free_idx < 0)
                                free_idx = i;
                        end else if (tbl_start[i] == r.io) begin
                            // same start: remap, bump only on a real change
                            if (tbl_len[i] != r.len || tbl_target[i] != r.ea) begin
                                tbl_len[i] = r.len;
                                tbl_target[i] = r.ea;
                                tbl_gen[i] = tbl_gen[i] + 32'd1;
                                tbl_epoch = tbl_epoch + 32'd1;
                            end
                            rsp.ok = 1'b1;
                            decided = 1'b1;
                        end else if (r.io < win_end && tbl_start[i] < req_end) begin
                            decided = 1'b1;
                        end
                    end
                end
                if (!decided && free_idx >= 0) begin
                    tbl_start[free_idx] = r.io;
                    tbl_target[free_idx] = r.ea;
                    tbl_len[free_idx] = r.len;
                    tbl_gen[free_idx] = tbl_gen[free_idx] + 32'd1;
                    tbl_live[free_idx] = 1'b1;
                    tbl_count = tbl_count + 5'd1;
                    tbl_epoch = tbl_epoch + 32'd1;
                    rsp.ok = 1'b1;
                end
            end
            OP_UNMAP: begin
                for (i = 0; i < SLOTS; i++) begin
                    if (!decided && tbl_live[i] && tbl_start[i] == r.io) begin
                        tbl_live[i] = 1'b0;
                        tbl_gen[i] = tbl_gen[i] + 32'd1;
                        tbl_count = tbl_count - 5'd1;
                        tbl_epoch = tbl_epoch + 32'd1;
                        rsp.ok = 1'b1;
                        decided = 1'b1;
                    end
                end
            end
            OP_RESOLVE: begin
                for (i = 0; i < SLOTS; i++) begin
                    off = r.io - tbl_start[i];
                    room = tbl_len[i] - off;
                    if (!decided && tbl_live[i] && r.io >= tbl_start[i]
                            && off <= tbl_len[i] && r.len <= room) begin
                        rsp.ok = 1'b1;
                        rsp.xlat = tbl_target[i] + off;
                        rsp.gen = tbl_gen[i];
                        decided = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        rsp.epoch = tbl_epoch;
        rsp.live = tbl_count;
        expected_q.push_back(rsp);
    endtask

    task automatic add_req(input logic [1:0] op, input logic [31:0] io,
                           input logic [31:0] ea, input logic [31:0] len, input bit hold);
        t_window_req r;
        r.op = op;
        r.io = io;
        r.ea = ea;
        r.len = len;
        r.hold = hold;
        pending_q.push_back(r);
    endtask

    // sender: bursts of words with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                predict_window_op(cur_req);
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_q.size() > 0
                        && (!pending_q[0].hold || expected_q.size() == 0)) begin
                    next_req = pending_q.pop_front();
                    cur_req <= next_req;
                    i_valid <= 1'b1;
                    i_operation <= next_req.op;
                    i_io_address <= next_req.io;
                    i_ea_address <= next_req.ea;
                    i_length <= next_req.len;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) != 0) ? $urandom_range(1, 8) : 0;
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each word against the oldest expectation, stall by mode
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected word", {31'd0, o_ok}, '0);
                end else begin
                    if (o_ok !== expected_q[0].ok)
                        report_mismatch("ok", {31'd0, o_ok}, {31'd0, expected_q[0].ok});
                    if (o_translated_address !== expected_q[0].xlat)
                        report_mismatch("translated_address", o_translated_address,
                                        expected_q[0].xlat);
                    if (o_window_generation !== expected_q[0].gen)
                        report_mismatch("window_generation", o_window_generation,
                                        expected_q[0].gen);
                    if (o_table_epoch !== expected_q[0].epoch)
                        report_mismatch("table_epoch", o_table_epoch, expected_q[0].epoch);
                    if (o_live_windows !== expected_q[0].live)
                        report_mismatch("live_windows", {27'd0, o_live_windows},
                                        {27'd0, expected_q[0].live});
                    void'(expected_q.pop_front());
                end
            end
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(30, 200);
                i_stall <= 1'b0;
            end else begin
                mode_left <= mode_left - 1;
                case (stall_mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    default: i_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
            timed_out <= 1'b1;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : stimulus
        int i;
        int k;
        int n;
        int sel;
        bit hold;
        for (i = 0; i < SLOTS; i++) begin
            tbl_start[i] = '0;
            tbl_target[i] = '0;
            tbl_len[i] = '0;
            tbl_gen[i] = '0;
            tbl_live[i] = 1'b0;
        end
        for (k = 0; k < NUM_REGIONS; k++) begin
            reg_start[k] = k * 32'h0A00_0000 + $urandom_range(0, 32'hFFFF);
            reg_ea[k] = $urandom;
            reg_len[k] = 32'h10;
        end
        reg_start[0] = '0;
        reg_ea[0] = 32'hFFFF_FFFF;
        reg_len[0] = 32'h200;
        reg_start[NUM_REGIONS - 1] = 32'hFFFF_FFF0;
        reg_ea[NUM_REGIONS - 1] = 32'h1234_5678;
        reg_len[NUM_REGIONS - 1] = 32'h20;

        // directed part
        add_req(OP_UNMAP, 32'h0, 32'h0, 32'h0, 1'b0);                 // unmap on empty table
        add_req(OP_MAP, 32'h0, 32'h5000, 32'h0, 1'b0);                // zero length
        add_req(OP_MAP, 32'h0, 32'hFFFF_FFFF, 32'h100, 1'b0);
        add_req(OP_MAP, 32'h0, 32'hFFFF_FFFF, 32'h200, 1'b0);         // remap with new length
        add_req(OP_MAP, 32'h80, 32'h0, 32'h10, 1'b0);                 // overlap
        add_req(OP_RESOLVE, 32'h0, 32'h0, 32'h200, 1'b0);             // whole window
        add_req(OP_RESOLVE, 32'h200, 32'h0, 32'h0, 1'b0);             // empty access at the end
        add_req(OP_RESOLVE, 32'h1F0, 32'h0, 32'h20, 1'b0);            // runs past the end
        add_req(OP_MAP, 32'hFFFF_FFF0, 32'h1234_5678, 32'h20, 1'b0);  // end wraps past zero
        add_req(OP_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        for (k = 1; k <= SLOTS - 2; k++)
            add_req(OP_MAP, reg_start[k], reg_ea[k], reg_len[k], 1'b0);
        add_req(OP_MAP, reg_start[SLOTS - 1], reg_ea[SLOTS - 1], 32'h10, 1'b0); // table full
        add_req(OP_MAP, reg_start[3], reg_ea[3], reg_len[3], 1'b0);   // unchanged remap
        add_req(OP_UNMAP, 32'h0, 32'h0, 32'h0, 1'b0);

        // random part, mostly on the region starts so that windows get reused
        for (n = 0; n < RANDOM_WORDS; n++) begin
            k = $urandom_range(0, NUM_REGIONS - 1);
            sel = $urandom_range(0, 99);
            hold = (n % 180 == 90);
            if (sel < 40) begin
                if ($urandom_range(0, 2) != 0) begin
                    reg_len[k] = $urandom_range(1, 32'h8000);
                    reg_ea[k] = $urandom;
                end
                add_req(OP_MAP, reg_start[k], reg_ea[k], reg_len[k], hold);
            end else if (sel < 47) begin
                add_req(OP_MAP, reg_start[k] + $urandom_range(1, 32'h100), $urandom,
                        $urandom_range(1, 32'h400), hold);
            end else if (sel < 49) begin
                add_req(OP_MAP, $urandom, $urandom,
                        ($urandom_range(0, 1) != 0) ? 32'h0 : $urandom, hold);
            end else if (sel < 65) begin
                add_req(OP_UNMAP, reg_start[k], $urandom, $urandom, hold);
            end else if (sel < 67) begin
                add_req(OP_UNMAP, $urandom, $urandom, $urandom, hold);
            end else if (sel < 93) begin
                add_req(OP_RESOLVE, reg_start[k] + $urandom_range(0, 32'h8800), $urandom,
                        $urandom_range(0, 32'h200), hold);
            end else if (sel < 96) begin
                add_req(OP_RESOLVE, $urandom, $urandom, $urandom, hold);
            end else begin
                add_req(OP_UNKNOWN, $urandom, $urandom, $urandom, hold);
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!timed_out
                && !(pending_q.size() == 0 && !i_valid && expected_q.size() == 0))
            @(negedge i_clk);

        if (timed_out) begin
            $display("%0t no word moved for %0d cycles, %0d results outstanding",
                     $realtime, IDLE_LIMIT, expected_q.size());
            $display("== FAIL ==");
        end else begin
            repeat (TAIL_CYCLES) @(posedge i_clk);
            if (expected_q.size() != 0)
                report_mismatch("words never delivered", expected_q.size(), '0);
            if (mismatch_count == 0)
                $display("== PASS ==");
            else
                $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- io_window_map_table_top.f -----
src/iwmt_pkg.sv
src/iwmt_ctrl.sv
src/iwmt_dp.sv
src/io_window_map_table_top.sv
dv/testbench.sv
